// ----- hw/rtl/fir16_pkg.sv -----
// shared types and constants of the 16-tap fir filter
package fir16_pkg;

  localparam int TAPS      = 16;
  localparam int TAP_WORDS = TAPS / 4;
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 32;
  localparam int CFG_W     = 64;
  localparam int INDEX_W   = 3;
  localparam int COUNT_W   = 4;

  localparam logic [COUNT_W-1:0] PRIMED = COUNT_W'(TAPS - 1);

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_TAPS_0_TO_3   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_TAPS_4_TO_7   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_TAPS_8_TO_11  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_TAPS_12_TO_15 = 3'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // control seen by each delay cell
  typedef struct packed {
    logic en;     // pipeline advances
    logic shift;  // a new sample enters the delay line
  } cell_ctrl_t;

  // control seen by the adder stages
  typedef struct packed {
    logic en;
    logic valid;  // products in the cells belong to a result
  } sum_ctrl_t;

endpackage

// ----- hw/rtl/fir16_if.sv -----
// request channels: sample input and filtered output
interface fir16_sample_if;
  logic                valid;
  logic                ready;
  fir16_pkg::sample_t  sample;
  logic                block_start;

  modport source (output valid, output sample, output block_start, input ready);
  modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface fir16_result_if;
  logic             valid;
  logic             ready;
  fir16_pkg::acc_t  filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// ----- hw/rtl/fir16_cell.sv -----
// one delay-line cell: holds a sample, passes it on, registers its tap product
module fir16_cell (
  input  logic                  clk,
  input  fir16_pkg::cell_ctrl_t ctrl,
  input  fir16_pkg::sample_t    d,
  input  fir16_pkg::sample_t    tap,
  output fir16_pkg::sample_t    q,
  output fir16_pkg::acc_t       prod
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= d;
    end
    if (ctrl.en) begin
      prod <= fir16_pkg::acc_t'(tap) * fir16_pkg::acc_t'(q);
    end
  end

endmodule

// ----- hw/rtl/fir16_sum.sv -----
// two-stage adder tree over the cell products, with the output register
module fir16_sum (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fir16_pkg::sum_ctrl_t                   ctrl,
  input  fir16_pkg::acc_t [fir16_pkg::TAPS-1:0]  prods,
  output fir16_pkg::acc_t                        sum,
  output logic                                   valid
);

  fir16_pkg::acc_t [fir16_pkg::TAP_WORDS-1:0] group;
  fir16_pkg::acc_t [fir16_pkg::TAP_WORDS-1:0] group_next;
  fir16_pkg::acc_t                            sum_next;
  logic                                       group_valid;

  always_comb begin
    for (int g = 0; g < fir16_pkg::TAP_WORDS; g++) begin
      group_next[g] = prods[4*g] + prods[4*g+1] + prods[4*g+2] + prods[4*g+3];
    end
    sum_next = '0;
    for (int g = 0; g < fir16_pkg::TAP_WORDS; g++) begin
      sum_next = sum_next + group[g];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      group <= group_next;
      sum   <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_valid <= 1'b0;
      valid       <= 1'b0;
    end else if (ctrl.en) begin
      group_valid <= ctrl.valid;
      valid       <= group_valid;
    end
  end

endmodule

// ----- hw/rtl/fir_filter_16_tap_core.sv -----
// top level of the 16-tap fir filter: delay-line cells, adder tree, config
// a result passes the cell product, group-sum and output registers after the sample completing it is accepted
// throughput: one sample per cycle; the whole pipeline holds while a result waits
// the first 15 samples after reset or a block start give no result
// reset clears the tap registers, the priming count and all valid flags
module fir_filter_16_tap_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fir16_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [fir16_pkg::CFG_W-1:0]          cfg_data,
  fir16_sample_if.sink                         samples,
  fir16_result_if.source                       results
);

  logic [fir16_pkg::TAP_WORDS-1:0][fir16_pkg::CFG_W-1:0] tap_words;
  logic [fir16_pkg::COUNT_W-1:0]                         cnt;
  logic [fir16_pkg::COUNT_W-1:0]                         cnt_base;
  logic [fir16_pkg::COUNT_W-1:0]                         cnt_next;
  logic                                                  en;
  logic                                                  accept;
  logic                                                  primed;
  logic                                                  window_valid;
  logic                                                  prod_valid;

  fir16_pkg::cell_ctrl_t                     cell_ctrl;
  fir16_pkg::sum_ctrl_t                      sum_ctrl;
  fir16_pkg::sample_t [fir16_pkg::TAPS-1:0]  taps;
  fir16_pkg::sample_t [fir16_pkg::TAPS:0]    line;
  fir16_pkg::acc_t    [fir16_pkg::TAPS-1:0]  prods;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_words <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fir16_pkg::REG_TAPS_0_TO_3:   tap_words[0] <= cfg_data;
        fir16_pkg::REG_TAPS_4_TO_7:   tap_words[1] <= cfg_data;
        fir16_pkg::REG_TAPS_8_TO_11:  tap_words[2] <= cfg_data;
        fir16_pkg::REG_TAPS_12_TO_15: tap_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < fir16_pkg::TAPS; k++) begin
      taps[k] = tap_words[k / 4][(k % 4) * fir16_pkg::SAMPLE_W +: fir16_pkg::SAMPLE_W];
    end
  end

  // one global enable: everything moves unless a finished result is stuck
  assign en            = !results.valid || results.ready;
  assign samples.ready = en;
  assign accept        = samples.valid && en;

  // priming count, a block start restarts it at this sample
  always_comb begin
    cnt_base = samples.block_start ? '0 : cnt;
    primed   = (cnt_base == fir16_pkg::PRIMED);
    cnt_next = primed ? fir16_pkg::PRIMED : cnt_base + 1'b1;
  end

  // window_valid lines up with the cell samples, prod_valid with the products
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      window_valid <= 1'b0;
      prod_valid   <= 1'b0;
    end else if (en) begin
      if (samples.valid) begin
        cnt <= cnt_next;
      end
      window_valid <= samples.valid && primed;
      prod_valid   <= window_valid;
    end
  end

  assign cell_ctrl.en    = en;
  assign cell_ctrl.shift = accept;

  // line[k+1] feeds cell k and line[k] is its output; the newest sample enters at the top end
  assign line[fir16_pkg::TAPS] = samples.sample;

  for (genvar k = 0; k < fir16_pkg::TAPS; k++) begin : g_cell
    fir16_cell u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl),
      .d    (line[k+1]),
      .tap  (taps[k]),
      .q    (line[k]),
      .prod (prods[k])
    );
  end

  assign sum_ctrl.en    = en;
  assign sum_ctrl.valid = prod_valid;

  fir16_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (sum_ctrl),
    .prods (prods),
    .sum   (results.filtered),
    .valid (results.valid)
  );

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.block_start) |=> (cnt == 4'd1))
    else $error("block start did not restart priming");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (accept && !samples.block_start) |=>
      (cnt == fir16_pkg::PRIMED || cnt == $past(cnt) + 4'd1))
    else $error("priming count skipped");

  a_window_primed: assert property (@(posedge clk) disable iff (rst)
    window_valid |-> (cnt == fir16_pkg::PRIMED))
    else $error("result window marked valid while priming");

endmodule
